FILE: hdl/dedge_pkg.sv
// shared types and constants of the diagonal edge filter
package dedge_pkg;

   localparam int PIX_W        = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int HEIGHT_W     = 13;
   localparam int ROW_W        = 12;
   localparam int MAX_HEIGHT   = 4096;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int KERNEL_BIAS  = 127;
   localparam int PIX_MAX      = 255;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // 3x3 neighborhood taps that carry a nonzero kernel weight
   typedef struct packed {
      pixel_type older_top;
      pixel_type prev_top;
      pixel_type older_mid;
      pixel_type prev_bottom;
      pixel_type right;
      pixel_type below_right;
   } window_type;

endpackage

FILE: hdl/dedge_channels.sv
// column request and filtered pixel response channel interfaces
interface dedge_req_if;
   import dedge_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pix_above;
   pixel_type pix_centre;
   pixel_type pix_below;

   modport source (output valid, output pix_above, output pix_centre, output pix_below,
                   input ready);
   modport sink (input valid, input pix_above, input pix_centre, input pix_below,
                 output ready);
endinterface

interface dedge_rsp_if;
   import dedge_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type out_pixel;
   logic      last_in_row;
   logic      last_in_frame;

   modport source (output valid, output out_pixel, output last_in_row, output last_in_frame,
                   input ready);
   modport sink (input valid, input out_pixel, input last_in_row, input last_in_frame,
                 output ready);
endinterface

FILE: hdl/dedge_kernel.sv
// diagonal kernel sum with bias and clamp
module dedge_kernel (
   input  dedge_pkg::window_type win,
   output dedge_pkg::pixel_type  pixel
);
   import dedge_pkg::*;

   logic [PIX_W+1:0]   neg_sum;
   logic [PIX_W+1:0]   pos_sum;
   logic signed [12:0] diff;
   logic signed [12:0] biased;

   always_comb begin
      neg_sum = {2'b0, win.older_top} + {2'b0, win.prev_top} + {2'b0, win.older_mid};
      pos_sum = {2'b0, win.prev_bottom} + {2'b0, win.right} + {2'b0, win.below_right};
      diff    = $signed({3'b0, pos_sum}) - $signed({3'b0, neg_sum});
      biased  = (diff <<< 1) + 13'(KERNEL_BIAS);
      if (biased < 0) begin
         pixel = '0;
      end else if (biased > 13'(PIX_MAX)) begin
         pixel = PIX_W'(PIX_MAX);
      end else begin
         pixel = biased[PIX_W-1:0];
      end
   end

endmodule

FILE: hdl/dedge_csr.sv
// size registers and the derived effective width, height and row padding
module dedge_csr #(
   parameter int MAX_WIDTH    = 4096,
   parameter int STRIDE_ALIGN = 4,
   parameter int WW           = 13,
   parameter int PAD_W        = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  dedge_pkg::csr_index_type  csr_index,
   input  logic [dedge_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [WW-1:0]             eff_width,
   output logic [dedge_pkg::HEIGHT_W-1:0] eff_height,
   output logic [PAD_W-1:0]          pad_count
);
   import dedge_pkg::*;

   localparam int WIDTH_CAP = (MAX_WIDTH < (2**CSR_DATA_W) - 1) ? MAX_WIDTH
                                                               : (2**CSR_DATA_W) - 1;
   localparam int RES_W = PAD_W;
   localparam int SUM_W = $clog2(WW * STRIDE_ALIGN + 1);
   localparam int HALF  = WW / 2;

   typedef logic [RES_W-1:0] weight_arr_type [WW];
   typedef logic [RES_W-1:0] mod_table_type [2**SUM_W];

   // residue of 2^i for each width bit
   function automatic weight_arr_type build_weights();
      weight_arr_type w;
      int m;
      m = 1 % STRIDE_ALIGN;
      for (int i = 0; i < WW; i++) begin
         w[i] = RES_W'(m);
         m = (m * 2) % STRIDE_ALIGN;
      end
      return w;
   endfunction

   function automatic mod_table_type build_mod_table();
      mod_table_type t;
      for (int i = 0; i < 2**SUM_W; i++) begin
         t[i] = RES_W'(i % STRIDE_ALIGN);
      end
      return t;
   endfunction

   localparam weight_arr_type BIT_WEIGHT = build_weights();
   localparam mod_table_type  MOD_TABLE  = build_mod_table();

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [WW-1:0]         weff_ff, weff_in;
   logic [HEIGHT_W-1:0]   heff_ff, heff_in;
   logic [PAD_W-1:0]      pads_ff, pads_in;
   logic [SUM_W-1:0]      sum_lo, sum_hi, wsum;
   logic [RES_W-1:0]      residue;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         weff_in = WW'(1);
      end else if (int'(width_ff) > WIDTH_CAP) begin
         weff_in = WW'(WIDTH_CAP);
      end else begin
         weff_in = WW'(width_ff);
      end

      if (height_ff == '0) begin
         heff_in = HEIGHT_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         heff_in = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         heff_in = height_ff;
      end

      // width mod stride alignment from per-bit residues
      sum_lo = '0;
      sum_hi = '0;
      for (int i = 0; i < HALF; i++) begin
         if (weff_in[i]) sum_lo = sum_lo + SUM_W'(BIT_WEIGHT[i]);
      end
      for (int i = HALF; i < WW; i++) begin
         if (weff_in[i]) sum_hi = sum_hi + SUM_W'(BIT_WEIGHT[i]);
      end
      wsum    = sum_lo + sum_hi;
      residue = MOD_TABLE[wsum];
      pads_in = (residue == '0) ? '0 : PAD_W'(STRIDE_ALIGN - int'(residue));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_W'(WIDTH_RESET);
         height_ff <= CSR_DATA_W'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // derived sizes track the registers in the following cycle
   always_ff @(posedge clock) begin
      weff_ff <= weff_in;
      heff_ff <= heff_in;
      pads_ff <= pads_in;
   end

   assign eff_width  = weff_ff;
   assign eff_height = heff_ff;
   assign pad_count  = pads_ff;

endmodule

FILE: hdl/diagonal_edge_3x3_filter_unit.sv
// top level of the 3x3 diagonal edge filter on a column stream
// The filter takes one image column (above, centre and below pixel) per transfer and returns
// one filtered pixel per column, offset by 127 and clamped to 0..255, emitted when the next
// column arrives; the first and last column of a row, the top and bottom row and the padding
// up to a multiple of STRIDE_ALIGN read as zero. A column goes through an input register and
// a result register before a result it causes can leave, and one column is taken every cycle
// while the response side keeps up. The last column of a row produces a burst of zero results
// (the last column itself plus the row padding, last_in_row on the final one); the input
// register holds the next column until the burst has left the result register. A size
// register write takes effect once it has passed the size register and the derived size
// register; writes never reset the column or row count. No clearing pass is needed after
// reset.
module diagonal_edge_3x3_filter_unit #(
   parameter int MAX_WIDTH    = 4096,
   parameter int STRIDE_ALIGN = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  dedge_pkg::csr_index_type         csr_index,
   input  logic [dedge_pkg::CSR_DATA_W-1:0] csr_wdata,
   dedge_req_if.sink                        req_chan,
   dedge_rsp_if.source                      rsp_chan
);
   import dedge_pkg::*;

   localparam int WIDTH_CAP = (MAX_WIDTH < (2**CSR_DATA_W) - 1) ? MAX_WIDTH
                                                               : (2**CSR_DATA_W) - 1;
   localparam int CW    = $clog2(WIDTH_CAP);          // column counter
   localparam int WW    = $clog2(WIDTH_CAP + 1);      // effective width
   localparam int PAD_W = (STRIDE_ALIGN > 1) ? $clog2(STRIDE_ALIGN) : 1;
   localparam int ZW    = $clog2(STRIDE_ALIGN + 1);   // zero burst length, up to STRIDE_ALIGN

   logic [WW-1:0]       eff_width;
   logic [HEIGHT_W-1:0] eff_height;
   logic [PAD_W-1:0]    pad_count;

   // input register
   logic      in_valid_ff, in_valid_in;
   pixel_type in_above_ff, in_centre_ff, in_below_ff;

   // column window and position
   pixel_type prev_top_ff, prev_mid_ff, prev_bottom_ff;
   pixel_type older_top_ff, older_mid_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // result register and pending zero burst
   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        out_pixel_ff, out_pixel_in;
   logic             last_row_ff, last_row_in;
   logic             last_frame_ff, last_frame_in;
   logic [ZW-1:0]    zeros_left_ff, zeros_left_in;
   logic             frame_end_ff, frame_end_in;

   logic             accept;
   logic             out_free;
   logic             consume;
   logic [WW-1:0]    col_plus;
   logic [HEIGHT_W-1:0] row_plus;
   logic             last_col;
   logic             last_row;
   logic             edge_row;
   logic             pix_zero;
   logic [ZW-1:0]    zeros_total;
   window_type       win;
   pixel_type        kernel_pix;

   dedge_csr #(
      .MAX_WIDTH    (MAX_WIDTH),
      .STRIDE_ALIGN (STRIDE_ALIGN),
      .WW           (WW),
      .PAD_W        (PAD_W)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .pad_count  (pad_count)
   );

   // the incoming column is the right neighbor of the pending one
   assign win = '{older_top:   older_top_ff,
                  prev_top:    prev_top_ff,
                  older_mid:   older_mid_ff,
                  prev_bottom: prev_bottom_ff,
                  right:       in_centre_ff,
                  below_right: in_below_ff};

   dedge_kernel u_kernel (
      .win   (win),
      .pixel (kernel_pix)
   );

   // position of the column in the input register
   always_comb begin
      col_plus    = WW'(col_ff) + WW'(1);
      row_plus    = HEIGHT_W'(row_ff) + HEIGHT_W'(1);
      last_col    = (col_plus >= eff_width);
      last_row    = (row_plus >= eff_height);
      edge_row    = (row_ff == '0) || last_row;
      // pending column is the first one, sits past the width, or on a border row
      pix_zero    = (col_ff == CW'(1)) || (WW'(col_ff) >= eff_width) || edge_row;
      zeros_total = ZW'(pad_count) + ZW'(1);
   end

   // pipeline control: zero bursts drain before the next column moves on
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      consume  = in_valid_ff && out_free && (zeros_left_ff == '0);
      accept   = req_chan.valid && req_chan.ready;

      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      out_pixel_in  = out_pixel_ff;
      last_row_in   = last_row_ff;
      last_frame_in = last_frame_ff;
      zeros_left_in = zeros_left_ff;
      frame_end_in  = frame_end_ff;

      if (out_free) begin
         if (zeros_left_ff != '0) begin
            // next zero of a row-end burst
            rsp_valid_in  = 1'b1;
            out_pixel_in  = '0;
            last_row_in   = (zeros_left_ff == ZW'(1));
            last_frame_in = (zeros_left_ff == ZW'(1)) && frame_end_ff;
            zeros_left_in = zeros_left_ff - ZW'(1);
         end else if (consume && (col_ff != '0)) begin
            // result of the pending column, never the last of a row
            rsp_valid_in  = 1'b1;
            out_pixel_in  = pix_zero ? '0 : kernel_pix;
            last_row_in   = 1'b0;
            last_frame_in = 1'b0;
            zeros_left_in = last_col ? zeros_total : '0;
            frame_end_in  = last_row;
         end else if (consume && last_col) begin
            // single-column row: the burst starts right away
            rsp_valid_in  = 1'b1;
            out_pixel_in  = '0;
            last_row_in   = (zeros_total == ZW'(1));
            last_frame_in = (zeros_total == ZW'(1)) && last_row;
            zeros_left_in = zeros_total - ZW'(1);
            frame_end_in  = last_row;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end

      col_in = col_ff;
      row_in = row_ff;
      if (consume) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_plus[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         zeros_left_ff  <= '0;
         frame_end_ff   <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
         prev_top_ff    <= '0;
         prev_mid_ff    <= '0;
         prev_bottom_ff <= '0;
         older_top_ff   <= '0;
         older_mid_ff   <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         zeros_left_ff <= zeros_left_in;
         frame_end_ff  <= frame_end_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         if (consume) begin
            older_top_ff   <= prev_top_ff;
            older_mid_ff   <= prev_mid_ff;
            prev_top_ff    <= in_above_ff;
            prev_mid_ff    <= in_centre_ff;
            prev_bottom_ff <= in_below_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_above_ff  <= req_chan.pix_above;
         in_centre_ff <= req_chan.pix_centre;
         in_below_ff  <= req_chan.pix_below;
      end
      out_pixel_ff  <= out_pixel_in;
      last_row_ff   <= last_row_in;
      last_frame_ff <= last_frame_in;
   end

   assign req_chan.ready         = !in_valid_ff || consume;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_pixel     = out_pixel_ff;
   assign rsp_chan.last_in_row   = last_row_ff;
   assign rsp_chan.last_in_frame = last_frame_ff;

   // frame end only ever marks a row end
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_frame_ff |-> last_row_ff)
      else $error("last_in_frame without last_in_row");

   // row end is always a padding or border zero
   a_row_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_row_ff |-> (out_pixel_ff == '0))
      else $error("row end result is not zero");

   // a pending burst always has a result in the output register
   a_burst_held: assert property (@(posedge clock) disable iff (reset)
      (zeros_left_ff != '0) |-> rsp_valid_ff)
      else $error("zero burst pending with empty result register");

   // the last column of a row restarts the column count
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      consume && last_col |=> (col_ff == '0))
      else $error("column count did not wrap at row end");

endmodule

FILE: sim/tb_diagonal_edge_3x3_filter_unit.sv
// self-checking testbench of the diagonal edge filter unit, directed table then random frames
module tb_diagonal_edge_3x3_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dedge_pkg::*;

   // block parameters at their defaults, mirrored for the pixel predictor
   localparam int COLS_MAX     = 4096;
   localparam int ALIGN        = 4;
   // cycles let pass after the last result before a size write or the end,
   // covers a column still in flight that causes no result
   localparam int DRAIN_CYCLES = 8;
   // long response hold-off so that the filter fills up and stalls its input
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 310;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int N_DIRECTED   = 25;

   // one filtered pixel as the response side carries it
   typedef struct packed {
      pixel_type pix;
      logic      row_end;
      logic      frame_end;
   } filt_out_type;

   // one row of the directed table: a size write or one column transfer,
   // optionally with the pixel of its first result typed in
   typedef struct packed {
      logic          is_write;
      csr_index_type reg_sel;
      logic [CSR_DATA_W-1:0] wdata;
      pixel_type     above;
      pixel_type     centre;
      pixel_type     below;
      logic          typed;
      pixel_type     typed_pix;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dedge_req_if req_if ();
   dedge_rsp_if rsp_if ();

   diagonal_edge_3x3_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always #5 clock = ~clock;

   // predictor copy of the size registers and of the column store
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   pixel_type last_above;
   pixel_type last_centre;
   pixel_type last_below;
   pixel_type earlier_above;
   pixel_type earlier_centre;
   int        col_pos;
   int        row_pos;

   // pixels caused by the column just predicted, and all pixels still owed
   filt_out_type column_outputs[$];
   filt_out_type pending_outputs[$];

   stim_row_type directed_rows [N_DIRECTED];

   int error_count = 0;
   // set per phase: neither side idles
   bit no_idle     = 1'b0;
   // bumped by the stimulus to ask the response side for one long hold-off
   int hold_asked  = 0;

   // zero width acts as one, oversize clamps to the maximum
   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > COLS_MAX) return COLS_MAX;
      return int'(width_reg);
   endfunction

   function automatic int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   // diagonal kernel on the stored columns plus the new column's centre and below pixel
   function automatic pixel_type diag_kernel(input pixel_type right, input pixel_type below_right);
      int neg;
      int pos;
      int v;
      neg = int'(earlier_above) + int'(last_above) + int'(earlier_centre);
      pos = int'(right) + int'(last_below) + int'(below_right);
      v = 2 * pos - 2 * neg + KERNEL_BIAS;
      if (v < 0) return '0;
      if (v > PIX_MAX) return pixel_type'(PIX_MAX);
      return pixel_type'(v);
   endfunction

   // works out the filtered pixels one column transfer causes and advances the counters
   function automatic void predict_column(input pixel_type a, input pixel_type c,
                                          input pixel_type b);
      int w;
      int h;
      int stride;
      int x;
      int i;
      bit last_col;
      bit last_row;
      bit edge_row;
      filt_out_type res;
      w = active_width();
      h = active_height();
      stride = ((w + ALIGN - 1) / ALIGN) * ALIGN;
      x = col_pos;
      last_col = (x + 1 >= w);
      last_row = (row_pos + 1 >= h);
      edge_row = (row_pos == 0) || last_row;
      column_outputs.delete();
      // pixel of the previous column, zero on first column, top/bottom row
      // and a column count left beyond a shrunk width
      if (x >= 1) begin
         res = '0;
         if (!(x == 1 || x >= w || edge_row))
            res.pix = diag_kernel(c, b);
         column_outputs.push_back(res);
      end
      // row end: zero for this column, then the stride padding, flags on the final one
      if (last_col) begin
         res = '0;
         for (i = 0; i < stride - w; i++)
            column_outputs.push_back(res);
         res.row_end = 1'b1;
         res.frame_end = last_row;
         column_outputs.push_back(res);
      end
      earlier_above = last_above;
      earlier_centre = last_centre;
      last_above = a;
      last_centre = c;
      last_below = b;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   function automatic stim_row_type column_row(input pixel_type a, input pixel_type c,
                                               input pixel_type b);
      stim_row_type r;
      r = '0;
      r.above = a;
      r.centre = c;
      r.below = b;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input pixel_type a, input pixel_type c,
                                                input pixel_type b, input pixel_type pix);
      stim_row_type r;
      r = column_row(a, c, b);
      r.typed = 1'b1;
      r.typed_pix = pix;
      return r;
   endfunction

   function automatic stim_row_type write_row(input csr_index_type sel,
                                              input logic [CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_sel = sel;
      r.wdata = value;
      return r;
   endfunction

   // extremes turn up often so that the clamp is hit on both sides
   function automatic pixel_type rand_pixel();
      case ($urandom_range(0, 5))
         0: begin
            return '0;
         end
         1: begin
            return pixel_type'(PIX_MAX);
         end
         default: begin
            return pixel_type'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // mostly small widths; zero, one, the maximum and oversize values now and then
   function automatic logic [CSR_DATA_W-1:0] pick_width();
      case ($urandom_range(0, 15))
         0: begin
            return '0;
         end
         1: begin
            return CSR_DATA_W'(1);
         end
         2: begin
            return CSR_DATA_W'(COLS_MAX);
         end
         3: begin
            return CSR_DATA_W'($urandom_range(COLS_MAX + 1, 8191));
         end
         default: begin
            return CSR_DATA_W'($urandom_range(2, 12));
         end
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height();
      case ($urandom_range(0, 11))
         0: begin
            return '0;
         end
         1: begin
            return CSR_DATA_W'(1);
         end
         2: begin
            return CSR_DATA_W'(MAX_HEIGHT);
         end
         3: begin
            return CSR_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
         end
         default: begin
            return CSR_DATA_W'($urandom_range(2, 6));
         end
      endcase
   endfunction

   // size write, only once the filter has gone idle
   task automatic write_register(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      // write is in effect for columns taken once the size and derived size registers have updated
      repeat (2) @(posedge clock);
      if (sel == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
   endtask

   // predicts one column, books its pixels and offers it until the transfer happens
   task automatic send_column(input pixel_type a, input pixel_type c, input pixel_type b,
                              input logic typed, input pixel_type typed_pix);
      int gap;
      int k;
      filt_out_type res;
      predict_column(a, c, b);
      for (k = 0; k < column_outputs.size(); k++) begin
         res = column_outputs[k];
         if (k == 0 && typed) res.pix = typed_pix;
         pending_outputs.push_back(res);
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high across back-to-back transfers
      req_if.valid <= 1'b1;
      req_if.pix_above <= a;
      req_if.pix_centre <= c;
      req_if.pix_below <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off on request, in-order check
   initial begin : response_side
      int rsp_wait;
      int hold_left;
      int holds_done;
      filt_out_type want;
      rsp_wait = 0;
      hold_left = 0;
      holds_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_outputs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transfer, expected none, actual pix %0d last %0b/%0b",
                        $time, rsp_if.out_pixel, rsp_if.last_in_row, rsp_if.last_in_frame);
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_if.out_pixel !== want.pix) begin
                  error_count++;
                  $display("%0t: out_pixel mismatch, expected %0d actual %0d",
                           $time, want.pix, rsp_if.out_pixel);
               end
               if (rsp_if.last_in_row !== want.row_end) begin
                  error_count++;
                  $display("%0t: last_in_row mismatch, expected %0b actual %0b",
                           $time, want.row_end, rsp_if.last_in_row);
               end
               if (rsp_if.last_in_frame !== want.frame_end) begin
                  error_count++;
                  $display("%0t: last_in_frame mismatch, expected %0b actual %0b",
                           $time, want.frame_end, rsp_if.last_in_frame);
               end
            end
            rsp_wait = no_idle ? 0 : $urandom_range(0, 10);
         end
         if (holds_done != hold_asked) begin
            holds_done = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // run limit, far above the slowest legal run
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int k;
      int phase;
      int items_sent;
      int count;
      int w;
      int sel;
      csr_we <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.pix_above <= '0;
      req_if.pix_centre <= '0;
      req_if.pix_below <= '0;

      // predictor in its after-reset state
      width_reg = CSR_DATA_W'(WIDTH_RESET);
      height_reg = CSR_DATA_W'(HEIGHT_RESET);
      last_above = '0;
      last_centre = '0;
      last_below = '0;
      earlier_above = '0;
      earlier_centre = '0;
      col_pos = 0;
      row_pos = 0;

      // 3 wide, 5 high: top row, max clamp row, min clamp row, flat row, bottom row;
      // then a 5 wide row with 3 pads (five pixels on its last column), then width one
      directed_rows = '{
         write_row(CSR_IMAGE_WIDTH, CSR_DATA_W'(3)),
         write_row(CSR_IMAGE_HEIGHT, CSR_DATA_W'(5)),
         // top row is all zero
         column_row(8'd10, 8'd20, 8'd30),
         checked_row(8'd255, 8'd255, 8'd255, 8'd0),
         checked_row(8'd0, 8'd0, 8'd0, 8'd0),
         // strong positive edge clamps high, first column still zero
         column_row(8'd0, 8'd0, 8'd255),
         checked_row(8'd0, 8'd0, 8'd255, 8'd0),
         checked_row(8'd0, 8'd0, 8'd255, 8'd255),
         // strong negative edge clamps low
         column_row(8'd255, 8'd255, 8'd0),
         checked_row(8'd255, 8'd255, 8'd0, 8'd0),
         checked_row(8'd255, 8'd255, 8'd0, 8'd0),
         // flat area gives the bias
         column_row(8'd0, 8'd0, 8'd0),
         checked_row(8'd0, 8'd0, 8'd0, 8'd0),
         checked_row(8'd0, 8'd0, 8'd0, 8'd127),
         // bottom row is all zero
         column_row(8'd255, 8'd255, 8'd255),
         checked_row(8'd255, 8'd255, 8'd255, 8'd0),
         checked_row(8'd255, 8'd255, 8'd255, 8'd0),
         write_row(CSR_IMAGE_WIDTH, CSR_DATA_W'(5)),
         column_row(8'h80, 8'h7f, 8'h01),
         checked_row(8'h01, 8'hfe, 8'h80, 8'd0),
         checked_row(8'haa, 8'h55, 8'hff, 8'd0),
         checked_row(8'h55, 8'haa, 8'h00, 8'd0),
         checked_row(8'hff, 8'h00, 8'h7f, 8'd0),
         // every column is first and last at once
         write_row(CSR_IMAGE_WIDTH, CSR_DATA_W'(1)),
         checked_row(8'h0f, 8'hf0, 8'h3c, 8'd0)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++) begin
         if (directed_rows[k].is_write)
            write_register(directed_rows[k].reg_sel, directed_rows[k].wdata);
         else
            send_column(directed_rows[k].above, directed_rows[k].centre,
                        directed_rows[k].below, directed_rows[k].typed,
                        directed_rows[k].typed_pix);
      end

      // random phases: new sizes, then mostly whole rows of random columns;
      // sometimes a broken row, which also leaves counts beyond the next shrunk size
      phase = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         no_idle = (phase == 0) || ($urandom_range(0, 3) == 0);
         sel = (phase == 0) ? 2 : $urandom_range(0, 2);
         if (sel != 1) write_register(CSR_IMAGE_WIDTH, pick_width());
         if (sel != 0) write_register(CSR_IMAGE_HEIGHT, pick_height());
         w = active_width();
         if (w > 16) count = $urandom_range(3, 20);
         else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 20);
         else count = w * $urandom_range(1, 4);
         // first phase: back-to-back columns against a long response hold-off
         if (phase == 0) begin
            hold_asked++;
            if (count < 30) count = 30;
         end
         repeat (count) send_column(rand_pixel(), rand_pixel(), rand_pixel(), 1'b0, '0);
         items_sent += count;
         phase++;
      end
      req_if.valid <= 1'b0;

      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
